// ----- rtl/atrf_pkg.sv -----
// Shared types, constants and the per-byte store function of the AT response line framer.
// Used by atrf_core, atrf_outq and at_response_line_framer; depends on nothing else.
package atrf_pkg;

  // Framing states.
  typedef enum logic [1:0] {
    FS_WAIT_CR1,
    FS_WAIT_LF1,
    FS_IN_LINE,
    FS_WAIT_LF2
  } frame_state_t;

  localparam logic [7:0]  CH_CR        = 8'h0D;
  localparam logic [7:0]  CH_LF        = 8'h0A;
  localparam logic [7:0]  CH_NUL       = 8'h00;
  localparam logic [10:0] BUFFER_BYTES = 11'd1024;
  localparam logic [10:0] LIMIT_MIN    = 11'd1;

  localparam logic [1:0] OK_LEN   = 2'd2;
  localparam logic [1:0] OK_DEAD  = 2'd3;
  localparam logic [2:0] ERR_LEN  = 3'd5;
  localparam logic [2:0] ERR_DEAD = 3'd6;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_OK    = 2'd1;
  localparam logic [1:0] CLASS_ERROR = 2'd2;

  // Framer context that carries across bytes.
  typedef struct packed {
    frame_state_t fstate;
    logic [10:0]  write_offset;
    logic [9:0]   line_begin;
    logic [10:0]  line_count;
    logic [1:0]   ok_progress;
    logic [2:0]   error_progress;
  } ctx_t;

  // One result item.
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [9:0]  position;
    logic [9:0]  line_start;
    logic [10:0] line_length;
    logic [1:0]  line_class;
    logic        wrapped;
    logic        last;
  } result_t;

  typedef struct packed {
    ctx_t    ctx;
    result_t res;
  } store_t;

  // Characters of "OK".
  function automatic logic [7:0] ok_char(input logic idx);
    logic [7:0] c;
    case (idx)
      1'b0:    c = 8'h4F;
      default: c = 8'h4B;
    endcase
    return c;
  endfunction

  // Characters of "ERROR".
  function automatic logic [7:0] err_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4F;
      3'd4:    c = 8'h52;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Bring a written limit into the range 1 to BUFFER_BYTES.
  function automatic logic [10:0] clamp_limit(input logic [10:0] v);
    logic [10:0] lim;
    lim = v;
    if (v < LIMIT_MIN) lim = LIMIT_MIN;
    else if (v > BUFFER_BYTES) lim = BUFFER_BYTES;
    return lim;
  endfunction

  // Store one byte or a line terminator: restart at the limit, advance the
  // offset and count, update the matchers and build the result item.
  function automatic store_t store_byte(input ctx_t ctx, input logic [7:0] b,
                                        input logic kind, input logic [10:0] lim);
    store_t st;
    logic   wrap;
    st.ctx = ctx;
    wrap   = (ctx.write_offset >= lim);
    if (wrap) begin
      st.ctx.write_offset   = '0;
      st.ctx.line_begin     = '0;
      st.ctx.line_count     = '0;
      st.ctx.ok_progress    = '0;
      st.ctx.error_progress = '0;
    end
    st.res.position        = st.ctx.write_offset[9:0];
    st.ctx.write_offset    = st.ctx.write_offset + 11'd1;
    st.ctx.line_count      = st.ctx.line_count + 11'd1;
    st.res.item_kind       = kind;
    st.res.line_start      = st.ctx.line_begin;
    st.res.line_length     = st.ctx.line_count;
    st.res.wrapped         = wrap;
    st.res.last            = 1'b0;
    if (kind == KIND_DATA) begin
      st.res.data_byte  = b;
      st.res.line_class = CLASS_OTHER;
      if (st.ctx.ok_progress < OK_LEN && b == ok_char(st.ctx.ok_progress[0]))
        st.ctx.ok_progress = st.ctx.ok_progress + 2'd1;
      else
        st.ctx.ok_progress = OK_DEAD;
      if (st.ctx.error_progress < ERR_LEN && b == err_char(st.ctx.error_progress))
        st.ctx.error_progress = st.ctx.error_progress + 3'd1;
      else
        st.ctx.error_progress = ERR_DEAD;
    end else begin
      st.res.data_byte = CH_NUL;
      if (st.ctx.ok_progress == OK_LEN) st.res.line_class = CLASS_OK;
      else if (st.ctx.error_progress == ERR_LEN) st.res.line_class = CLASS_ERROR;
      else st.res.line_class = CLASS_OTHER;
    end
    return st;
  endfunction

endpackage

// ----- rtl/at_response_line_framer.sv -----
// Top level of the AT response line framer: input register, framing core and result queue.
// Depends on atrf_pkg, atrf_core and atrf_outq.
//
//  Channel  Signals                              Direction  Moves
//  input    in_valid, in_stall, rx_byte          in         one received byte
//  output   out_valid, out_stall, item_kind..    out        one stored byte or line end
//  config   cfg_valid, cfg_ready, cfg_data       in         buffer_limit write
//
// A byte is registered, then framed into zero, one or two results once the queue has room.
// One byte is taken per cycle while in_stall is low; a byte that yields two results
// makes two output transactions, since the result queue hands out one per cycle when out_stall is low.
// Reset is synchronous and clears framing state, the queue and sets the limit to 1024.
// A stall on the output backs up into in_stall once the queue cannot hold two more results.
module at_response_line_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        item_kind,
  output logic [7:0]  data_byte,
  output logic [9:0]  position,
  output logic [9:0]  line_start,
  output logic [10:0] line_length,
  output logic [1:0]  line_class,
  output logic        wrapped,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              go;
  logic              room;
  logic              in_take;
  logic [1:0]        res_n;
  atrf_pkg::result_t res0;
  atrf_pkg::result_t res1;
  atrf_pkg::result_t head_res;

  // Handshake control.
  assign cfg_ready = 1'b1;
  assign go        = hold_valid && room;
  assign in_stall  = hold_valid && !room;
  assign in_take   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) hold_byte <= rx_byte;
  end

  // Framing core.
  atrf_core u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .byte_in  (hold_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res_n    (res_n),
    .res0     (res0),
    .res1     (res1)
  );

  // Result queue.
  atrf_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_n     (go ? res_n : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (!out_stall),
    .head_res   (head_res),
    .head_valid (out_valid),
    .room       (room)
  );

  // Output fields.
  assign item_kind   = head_res.item_kind;
  assign data_byte   = head_res.data_byte;
  assign position    = head_res.position;
  assign line_start  = head_res.line_start;
  assign line_length = head_res.line_length;
  assign line_class  = head_res.line_class;
  assign wrapped     = head_res.wrapped;
  assign last        = head_res.last;

  // A processed byte with results makes the output valid in the next cycle.
  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    go && res_n != 2'd0 |=> out_valid)
    else $error("result produced but output not valid");

  // The core never reports more than two results.
  a_res_count: assert property (@(posedge clk) disable iff (rst)
    go |-> res_n != 2'd3)
    else $error("core reported three results");

  // A restarted store always lands at offset zero.
  a_wrap_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && wrapped |-> position == 10'd0 && line_length == 11'd1)
    else $error("wrapped store not at offset zero");

  // A line end carries a zero byte and ends its transaction group.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == atrf_pkg::KIND_END |-> data_byte == atrf_pkg::CH_NUL && last)
    else $error("line end with nonzero byte or not last");

endmodule

// ----- rtl/atrf_core.sv -----
// Framing core of the AT response line framer: context registers, limit register and
// the per-byte logic that yields zero, one or two result items. Depends on atrf_pkg.
module atrf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        byte_in,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_data,
  output logic [1:0]        res_n,
  output atrf_pkg::result_t res0,
  output atrf_pkg::result_t res1
);

  atrf_pkg::ctx_t      ctx;
  atrf_pkg::ctx_t      ctx_next;
  logic [10:0]         limit;

  // Per-byte framing decision.
  always_comb begin
    atrf_pkg::store_t st0;
    atrf_pkg::store_t st1;
    st0      = '0;
    st1      = '0;
    ctx_next = ctx;
    res0     = '0;
    res1     = '0;
    res_n    = 2'd0;
    unique case (ctx.fstate)
      atrf_pkg::FS_WAIT_CR1: begin
        if (byte_in == atrf_pkg::CH_CR) ctx_next.fstate = atrf_pkg::FS_WAIT_LF1;
      end
      atrf_pkg::FS_WAIT_LF1: begin
        if (byte_in == atrf_pkg::CH_LF) begin
          ctx_next.fstate         = atrf_pkg::FS_IN_LINE;
          ctx_next.line_count     = '0;
          ctx_next.line_begin     = ctx.write_offset[9:0];
          ctx_next.ok_progress    = '0;
          ctx_next.error_progress = '0;
        end else begin
          ctx_next.fstate = atrf_pkg::FS_WAIT_CR1;
        end
      end
      atrf_pkg::FS_IN_LINE: begin
        if (byte_in == atrf_pkg::CH_CR) begin
          ctx_next.fstate = atrf_pkg::FS_WAIT_LF2;
        end else begin
          st0      = atrf_pkg::store_byte(ctx, byte_in, atrf_pkg::KIND_DATA, limit);
          ctx_next = st0.ctx;
          res0     = st0.res;
          res_n    = 2'd1;
        end
      end
      atrf_pkg::FS_WAIT_LF2: begin
        if (byte_in == atrf_pkg::CH_LF) begin
          st0             = atrf_pkg::store_byte(ctx, atrf_pkg::CH_NUL,
                                                 atrf_pkg::KIND_END, limit);
          ctx_next        = st0.ctx;
          ctx_next.fstate = atrf_pkg::FS_WAIT_CR1;
          res0            = st0.res;
          res_n           = 2'd1;
        end else if (byte_in == atrf_pkg::CH_CR) begin
          st0      = atrf_pkg::store_byte(ctx, atrf_pkg::CH_CR, atrf_pkg::KIND_DATA, limit);
          ctx_next = st0.ctx;
          res0     = st0.res;
          res_n    = 2'd1;
        end else begin
          // A lone CR is kept as data, followed by the byte after it.
          st0             = atrf_pkg::store_byte(ctx, atrf_pkg::CH_CR,
                                                 atrf_pkg::KIND_DATA, limit);
          st1             = atrf_pkg::store_byte(st0.ctx, byte_in,
                                                 atrf_pkg::KIND_DATA, limit);
          ctx_next        = st1.ctx;
          ctx_next.fstate = atrf_pkg::FS_IN_LINE;
          res0            = st0.res;
          res1            = st1.res;
          res_n           = 2'd2;
        end
      end
      default: ctx_next = ctx;
    endcase
    // Mark the final result of this byte.
    if (res_n == 2'd1) res0.last = 1'b1;
    if (res_n == 2'd2) res1.last = 1'b1;
  end

  // Context register advances only when a byte is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.fstate         <= atrf_pkg::FS_WAIT_CR1;
      ctx.write_offset   <= '0;
      ctx.line_begin     <= '0;
      ctx.line_count     <= '0;
      ctx.ok_progress    <= '0;
      ctx.error_progress <= '0;
    end else if (go) begin
      ctx <= ctx_next;
    end
  end

  // Limit register holds the clamped value of the last write.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= atrf_pkg::BUFFER_BYTES;
    end else if (cfg_we) begin
      limit <= atrf_pkg::clamp_limit(cfg_data);
    end
  end

endmodule

// ----- rtl/atrf_outq.sv -----
// Four-entry result queue of the AT response line framer; takes up to two results
// per cycle and hands one out per transaction. Depends on atrf_pkg.
module atrf_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  atrf_pkg::result_t push0,
  input  atrf_pkg::result_t push1,
  input  logic              pop,
  output atrf_pkg::result_t head_res,
  output logic              head_valid,
  output logic              room
);

  atrf_pkg::result_t entries [4];
  logic [1:0]        head;
  logic [2:0]        count;
  logic [1:0]        tail;
  logic              do_pop;

  assign tail       = head + count[1:0];
  assign head_valid = (count != 3'd0);
  assign do_pop     = pop && head_valid;
  // Room for the two results a single byte may produce.
  assign room       = (count <= 3'd2);
  assign head_res   = entries[head];

  // Entry writes.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entries[tail] <= push0;
    if (push_n == 2'd2) entries[tail + 2'd1] <= push1;
  end

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (do_pop) head <= head + 2'd1;
      count <= count + {1'b0, push_n} - {2'b00, do_pop};
    end
  end

endmodule

// ----- tb/at_response_line_framer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for at_response_line_framer: random and directed byte streams,
// each framed line predicted in the bench and compared against the block's result stream.
// Depends on atrf_pkg and the at_response_line_framer RTL.
module at_response_line_framer_tb;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  // Text of the two recognized response lines.
  localparam logic [15:0] OK_WORD  = "OK";
  localparam logic [39:0] ERR_WORD = "ERROR";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        item_kind;
  logic [7:0]  data_byte;
  logic [9:0]  position;
  logic [9:0]  line_start;
  logic [10:0] line_length;
  logic [1:0]  line_class;
  logic        wrapped;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = 11'd0;

  // Bytes waiting to be sent and results waiting to be seen.
  logic [7:0]        rx_queue [$];
  atrf_pkg::result_t awaited_results [$];
  int                pushed_total = 0;
  int                failure_count = 0;

  // Idle rates in percent and the long receiver hold-off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_burst_request = 0;
  int stall_burst_left = 0;

  // Bench copy of the framer context and the buffer limit.
  atrf_pkg::frame_state_t fr_state = atrf_pkg::FS_WAIT_CR1;
  logic [10:0]  wr_offset = 11'd0;
  logic [9:0]   ln_begin = 10'd0;
  logic [10:0]  ln_count = 11'd0;
  logic [1:0]   ok_match = 2'd0;
  logic [2:0]   err_match = 3'd0;
  logic [10:0]  limit_reg = atrf_pkg::BUFFER_BYTES;

  at_response_line_framer uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .item_kind   (item_kind),
    .data_byte   (data_byte),
    .position    (position),
    .line_start  (line_start),
    .line_length (line_length),
    .line_class  (line_class),
    .wrapped     (wrapped),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Store one payload byte or line terminator in the bench buffer and build its result.
  function automatic atrf_pkg::result_t store_into_buffer(input logic [7:0] b,
                                                          input logic kind);
    atrf_pkg::result_t r;
    logic [10:0]       lim;
    lim = limit_reg;
    if (lim == 11'd0) begin
      lim = 11'd1;
    end else if (lim > atrf_pkg::BUFFER_BYTES) begin
      lim = atrf_pkg::BUFFER_BYTES;
    end
    r.wrapped = 1'b0;
    if (wr_offset >= lim) begin
      wr_offset = '0;
      ln_begin  = '0;
      ln_count  = '0;
      ok_match  = '0;
      err_match = '0;
      r.wrapped = 1'b1;
    end
    r.position    = wr_offset[9:0];
    wr_offset     = wr_offset + 11'd1;
    ln_count      = ln_count + 11'd1;
    r.item_kind   = kind;
    r.line_start  = ln_begin;
    r.line_length = ln_count;
    r.last        = 1'b0;
    if (kind == atrf_pkg::KIND_DATA) begin
      r.data_byte  = b;
      r.line_class = atrf_pkg::CLASS_OTHER;
      // Both matchers advance on the expected character and die on anything else.
      if (ok_match < atrf_pkg::OK_LEN && b == OK_WORD[15 - 8 * int'(ok_match) -: 8]) begin
        ok_match = ok_match + 2'd1;
      end else begin
        ok_match = atrf_pkg::OK_DEAD;
      end
      if (err_match < atrf_pkg::ERR_LEN && b == ERR_WORD[39 - 8 * int'(err_match) -: 8]) begin
        err_match = err_match + 3'd1;
      end else begin
        err_match = atrf_pkg::ERR_DEAD;
      end
    end else begin
      r.data_byte = atrf_pkg::CH_NUL;
      if (ok_match == atrf_pkg::OK_LEN) begin
        r.line_class = atrf_pkg::CLASS_OK;
      end else if (err_match == atrf_pkg::ERR_LEN) begin
        r.line_class = atrf_pkg::CLASS_ERROR;
      end else begin
        r.line_class = atrf_pkg::CLASS_OTHER;
      end
    end
    return r;
  endfunction

  // Frame one accepted byte and queue the zero, one or two results it causes.
  task automatic frame_rx_byte(input logic [7:0] b);
    atrf_pkg::result_t outs [2];
    int                n;
    n = 0;
    case (fr_state)
      atrf_pkg::FS_WAIT_CR1: begin
        if (b == atrf_pkg::CH_CR) fr_state = atrf_pkg::FS_WAIT_LF1;
      end
      atrf_pkg::FS_WAIT_LF1: begin
        if (b == atrf_pkg::CH_LF) begin
          fr_state  = atrf_pkg::FS_IN_LINE;
          ln_count  = '0;
          ln_begin  = wr_offset[9:0];
          ok_match  = '0;
          err_match = '0;
        end else begin
          fr_state = atrf_pkg::FS_WAIT_CR1;
        end
      end
      atrf_pkg::FS_IN_LINE: begin
        if (b == atrf_pkg::CH_CR) begin
          fr_state = atrf_pkg::FS_WAIT_LF2;
        end else begin
          outs[n] = store_into_buffer(b, atrf_pkg::KIND_DATA);
          n++;
        end
      end
      atrf_pkg::FS_WAIT_LF2: begin
        // A CR not followed by LF is kept as data.
        if (b == atrf_pkg::CH_LF) begin
          outs[n] = store_into_buffer(atrf_pkg::CH_NUL, atrf_pkg::KIND_END);
          n++;
          fr_state = atrf_pkg::FS_WAIT_CR1;
        end else if (b == atrf_pkg::CH_CR) begin
          outs[n] = store_into_buffer(atrf_pkg::CH_CR, atrf_pkg::KIND_DATA);
          n++;
        end else begin
          outs[n] = store_into_buffer(atrf_pkg::CH_CR, atrf_pkg::KIND_DATA);
          n++;
          outs[n] = store_into_buffer(b, atrf_pkg::KIND_DATA);
          n++;
          fr_state = atrf_pkg::FS_IN_LINE;
        end
      end
    endcase
    if (n > 0) outs[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited_results.push_back(outs[i]);
  endtask

  function automatic string show_result(input atrf_pkg::result_t r);
    return $sformatf("kind=%0d data=%02h pos=%0d start=%0d len=%0d class=%0d wrap=%0d last=%0d",
                     r.item_kind, r.data_byte, r.position, r.line_start, r.line_length,
                     r.line_class, r.wrapped, r.last);
  endfunction

  task automatic record_failure(input string what);
    if (failure_count < MAX_REPORTS) $display("mismatch: %s", what);
    failure_count++;
  endtask

  // Input driver: hold a stalled transaction, otherwise offer the next byte or idle.
  always @(posedge clk) begin : drive_rx
    logic [7:0] sent;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sent = rx_queue.pop_front();
        frame_rx_byte(sent);
      end
      if (!(in_valid && in_stall)) begin
        if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each accepted result and decide the next stall.
  always @(posedge clk) begin : check_results
    atrf_pkg::result_t seen;
    atrf_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {item_kind, data_byte, position, line_start, line_length,
                line_class, wrapped, last};
        if (awaited_results.size() == 0) begin
          record_failure($sformatf("unexpected result %s", show_result(seen)));
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            record_failure($sformatf("expected %s, got %s", show_result(want),
                                     show_result(seen)));
          end
        end
      end
      if (stall_burst_request != 0) begin
        stall_burst_left    = stall_burst_request;
        stall_burst_request = 0;
      end
      if (stall_burst_left != 0) begin
        stall_burst_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("at_response_line_framer_tb NOT OK");
    $finish;
  end

  task automatic push_rx(input logic [7:0] b);
    rx_queue.push_back(b);
    pushed_total++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_rx(s[i]);
  endtask

  // Line content: mostly printable, with CR, LF, matcher letters and raw bytes mixed in.
  function automatic logic [7:0] pick_line_byte();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 8'($urandom_range(32, 126));
    if (sel < 65) return atrf_pkg::CH_CR;
    if (sel < 70) return atrf_pkg::CH_LF;
    if (sel < 80) begin
      case ($urandom_range(3))
        0:       return "O";
        1:       return "K";
        2:       return "E";
        default: return "R";
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Mostly framed lines with random content, the rest noise and broken frames.
  task automatic queue_random_traffic(input int count);
    int start;
    int len;
    start = pushed_total;
    while (pushed_total - start < count) begin
      if ($urandom_range(99) < 82) begin
        push_rx(atrf_pkg::CH_CR);
        push_rx(atrf_pkg::CH_LF);
        case ($urandom_range(9))
          0: push_text("OK");
          1: push_text("ERROR");
          2: begin
            case ($urandom_range(5))
              0:       push_text("O");
              1:       push_text("OKK");
              2:       push_text("ERRO");
              3:       push_text("ERRORR");
              4:       push_text("KO");
              default: push_text("EOK");
            endcase
          end
          default: begin
            len = ($urandom_range(15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            repeat (len) push_rx(pick_line_byte());
          end
        endcase
        if ($urandom_range(9) != 0) begin
          push_rx(atrf_pkg::CH_CR);
          push_rx(atrf_pkg::CH_LF);
        end else if ($urandom_range(1) == 0) begin
          push_rx(atrf_pkg::CH_CR);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(2))
            0:       push_rx(atrf_pkg::CH_CR);
            1:       push_rx(atrf_pkg::CH_LF);
            default: push_rx(8'($urandom_range(255)));
          endcase
        end
      end
    end
  endtask

  // One long line with no CR inside, so that it runs past the buffer end.
  task automatic queue_long_line(input int len);
    logic [7:0] b;
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_LF);
    repeat (len) begin
      b = 8'($urandom_range(255));
      if (b == atrf_pkg::CH_CR) b = 8'h20;
      push_rx(b);
    end
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_LF);
  endtask

  // Wait until every byte is sent and every result seen, then let the pipeline empty.
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_queue.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the buffer limit through the configuration channel while the block is idle.
  task automatic write_limit(input logic [10:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = value;
    @(negedge clk);
  endtask

  // Test sequence: directed lines, then random phases over several limits and idle mixes.
  initial begin : run_test
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 79;

    // Dropped noise, a CR that breaks the opening pair, then an OK line.
    push_rx(8'h55);
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_LF);
    push_text("OK");
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_LF);
    // An ERROR line.
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_LF);
    push_text("ERROR");
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_LF);
    // Zero and all-ones bytes, a CR followed by CR and a CR followed by a letter.
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_LF);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_CR);
    push_rx("A");
    push_rx(atrf_pkg::CH_CR);
    push_rx(atrf_pkg::CH_LF);
    wait_drained();

    queue_random_traffic(150);
    wait_drained();

    // A limit above the buffer size acts as the buffer size; run past its end.
    write_limit(11'd2047);
    queue_long_line(1030 - int'(wr_offset));
    queue_random_traffic(30);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 32;
    write_limit(11'd1);
    queue_random_traffic(60);
    wait_drained();

    write_limit(11'd0);
    queue_random_traffic(30);
    wait_drained();

    // No idling, and one long receiver hold-off so that the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(11'd7);
    queue_random_traffic(120);
    stall_burst_request = 150;
    wait_drained();

    write_limit(atrf_pkg::BUFFER_BYTES);
    queue_random_traffic(50);
    wait_drained();

    repeat (10) @(negedge clk);
    if (failure_count == 0) begin
      $display("at_response_line_framer_tb OK");
    end else begin
      $display("at_response_line_framer_tb NOT OK");
    end
    $finish;
  end

endmodule
